// File: design/assert_macros.svh
// Assertion macros shared by the locator modules.
// Both expect a signal named clk, and ESDSL_ASSERT also rst_n, in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ESDSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ESDSL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: design/esdsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esdsl_pkg
// Types and constants shared by the esds audio config locator modules.
// ----------------------------------------------------------------------------
package esdsl_pkg;

  localparam int MAX_BYTES_DEF = 65536;

  // Buffer positions and descriptor end positions.
  localparam int END_W = 29;
  // Expandable length accumulator.
  localparam int ACC_W = 28;
  localparam int CNT_W = 3;
  localparam int OUT_W = 16;

  localparam logic [31:0] ESDS_TAG     = 32'h6573_6473;
  localparam logic [31:0] BOX_MIN_SIZE = 32'd12;
  localparam int          HDR_LEN      = 8;
  localparam int          HDR_LAST     = 7;

  localparam logic [7:0] TAG_ES       = 8'd3;
  localparam logic [7:0] TAG_DC       = 8'd4;
  localparam logic [7:0] TAG_ASC      = 8'd5;
  localparam logic [7:0] OBJ_AUDIO    = 8'h40;
  localparam logic [5:0] STREAM_AUDIO = 6'd5;

  localparam int MIN_ES_LEN    = 3;
  localparam int MIN_DC_LEN    = 13;
  localparam int MIN_ASC_LEN   = 2;
  localparam int MAX_LEN_BYTES = 4;
  localparam int VF_SKIP       = 3;
  localparam int OPT_SKIP      = 2;
  localparam int ES_ID_SKIP    = 2;
  localparam int DC_SKIP_LEN   = 11;
  localparam int OFS_MAX       = 65535;

  typedef struct packed {
    logic        tag_hit;
    logic [31:0] size;
  } hdr_info_t;

  typedef struct packed {
    logic             ok_pre;
    logic             box_mode;
    logic [31:0]      box_size;
    logic [END_W-1:0] es_end;
    logic [END_W-1:0] asc_start;
    logic [END_W-1:0] asc_end;
    logic [END_W-1:0] count;
  } fin_t;

endpackage

// File: design/esdsl_hdr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esdsl_hdr
// Keeps the last seven bytes and spots an outer esds box header when the
// eighth byte arrives.
// ----------------------------------------------------------------------------
module esdsl_hdr
  import esdsl_pkg::*;
(
  input  logic      clk,
  input  logic      take,
  input  logic [7:0] in_byte,
  output hdr_info_t hdr
);

  logic [(HDR_LEN-1)*8-1:0] hist_r;

  always_ff @(posedge clk) begin
    if (take) begin
      hist_r <= {hist_r[(HDR_LEN-2)*8-1:0], in_byte};
    end
  end

  always_comb begin
    hdr.tag_hit = ({hist_r[23:0], in_byte} == ESDS_TAG);
    hdr.size    = hist_r[(HDR_LEN-1)*8-1:(HDR_LEN-1)*8-32];
  end

endmodule

// File: design/esdsl_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esdsl_parser
// Byte engine: walks the ES, DecoderConfig and DecSpecificInfo descriptors,
// one byte per cycle while take is high, and hands the final state to the result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esdsl_parser
  import esdsl_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  hdr_info_t  hdr,
  output logic       fin_load,
  output fin_t       fin
);

  localparam int POS_W = $clog2(MAX_BYTES + 1);

  typedef enum logic [3:0] {
    PH_VF, PH_VFZ, PH_TAG_ES, PH_LEN_ES, PH_ES_ID, PH_ES_FLAGS, PH_ES_SKIP,
    PH_URL_LEN, PH_TAG_DC, PH_LEN_DC, PH_DC_OBJ, PH_DC_ST, PH_DC_SKIP,
    PH_TAG_ASC, PH_LEN_ASC, PH_DONE
  } phase_t;

  typedef struct packed {
    logic             fail;
    logic             done;
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic [END_W-1:0] e;
  } len_res_t;

  typedef struct packed {
    logic       fail;
    phase_t     ph;
    logic [2:0] opt;
    logic       ld_skip;
  } es_nx_t;

  function automatic len_res_t len_step(input logic [7:0] b, input logic [END_W-1:0] p,
                                        input logic bounded, input logic [31:0] limit,
                                        input logic [ACC_W-1:0] acc,
                                        input logic [CNT_W-1:0] cnt);
    len_res_t    r;
    logic [31:0] p32;
    logic [31:0] room;
    r.acc  = {acc[ACC_W-8:0], b[6:0]};
    r.cnt  = cnt + CNT_W'(1);
    p32    = 32'(p);
    room   = limit - (p32 + 32'd1);
    r.e    = p + END_W'(1) + END_W'(r.acc);
    r.fail = 1'b0;
    r.done = 1'b0;
    if (bounded && (p32 >= limit)) begin
      r.fail = 1'b1;
    end else if (b[7]) begin
      if (r.cnt >= CNT_W'(MAX_LEN_BYTES)) r.fail = 1'b1;
    end else if (bounded && (32'(r.acc) > room)) begin
      r.fail = 1'b1;
    end else begin
      r.done = 1'b1;
    end
    return r;
  endfunction

  // Picks the next optional ES header field, in the order dependency id,
  // URL, OCR id, given the position q of the following byte.
  function automatic es_nx_t es_next(input logic [END_W-1:0] q, input logic [2:0] opt,
                                     input logic [END_W-1:0] es_end);
    es_nx_t           r;
    logic [END_W-1:0] q2;
    q2        = q + END_W'(OPT_SKIP);
    r.fail    = 1'b0;
    r.ph      = PH_TAG_DC;
    r.opt     = opt;
    r.ld_skip = 1'b0;
    if (opt[2]) begin
      r.opt[2] = 1'b0;
      if (q2 > es_end) r.fail = 1'b1;
      r.ph      = PH_ES_SKIP;
      r.ld_skip = 1'b1;
    end else if (opt[1]) begin
      r.opt[1] = 1'b0;
      if (q >= es_end) r.fail = 1'b1;
      r.ph = PH_URL_LEN;
    end else if (opt[0]) begin
      r.opt[0] = 1'b0;
      if (q2 > es_end) r.fail = 1'b1;
      r.ph      = PH_ES_SKIP;
      r.ld_skip = 1'b1;
    end
    return r;
  endfunction

  phase_t           phase_r,     phase_nxt;
  logic [POS_W-1:0] pos_r,       pos_nxt;
  logic             failed_r,    failed_nxt;
  logic             box_mode_r,  box_mode_nxt;
  logic [31:0]      box_size_r,  box_size_nxt;
  logic [ACC_W-1:0] acc_r,       acc_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  logic [END_W-1:0] es_end_r,    es_end_nxt;
  logic [END_W-1:0] dc_end_r,    dc_end_nxt;
  logic [END_W-1:0] asc_end_r,   asc_end_nxt;
  logic [END_W-1:0] asc_start_r, asc_start_nxt;
  logic [2:0]       opt_r,       opt_nxt;
  logic [7:0]       skip_r,      skip_nxt;

  logic [END_W-1:0] pe;
  logic [END_W-1:0] p1;
  logic             proc;
  logic             ls_bounded;
  logic [31:0]      ls_limit;
  len_res_t         ls;
  es_nx_t           esn;

  always_comb begin
    pe   = END_W'(pos_r);
    p1   = pe + END_W'(1);
    proc = take && (pos_r < POS_W'(MAX_BYTES));

    case (phase_r)
      PH_LEN_ES: begin
        ls_bounded = box_mode_r;
        ls_limit   = box_size_r;
      end
      PH_LEN_DC: begin
        ls_bounded = 1'b1;
        ls_limit   = 32'(es_end_r);
      end
      default: begin
        ls_bounded = 1'b1;
        ls_limit   = 32'(dc_end_r);
      end
    endcase
    ls  = len_step(in_byte, pe, ls_bounded, ls_limit, acc_r, cnt_r);
    esn = es_next(p1, (phase_r == PH_ES_FLAGS) ? in_byte[7:5] : opt_r, es_end_r);

    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    failed_nxt    = failed_r;
    box_mode_nxt  = box_mode_r;
    box_size_nxt  = box_size_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    es_end_nxt    = es_end_r;
    dc_end_nxt    = dc_end_r;
    asc_end_nxt   = asc_end_r;
    asc_start_nxt = asc_start_r;
    opt_nxt       = opt_r;
    skip_nxt      = skip_r;

    if (take && !proc) failed_nxt = 1'b1;

    if (proc) begin
      pos_nxt = pos_r + POS_W'(1);
      if (!failed_r && (phase_r != PH_DONE)) begin
        case (phase_r)
          PH_VF, PH_TAG_ES: begin
            if ((phase_r == PH_VF) && (in_byte == 8'd0)) begin
              skip_nxt  = 8'(VF_SKIP);
              phase_nxt = PH_VFZ;
            end else if ((box_mode_r && (32'(pos_r) >= box_size_r)) ||
                         (in_byte != TAG_ES)) begin
              failed_nxt = 1'b1;
            end else begin
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_LEN_ES;
            end
          end
          PH_VFZ: begin
            if (in_byte != 8'd0) begin
              failed_nxt = 1'b1;
            end else begin
              skip_nxt = skip_r - 8'd1;
              if (skip_r == 8'd1) phase_nxt = PH_TAG_ES;
            end
          end
          PH_LEN_ES, PH_LEN_DC, PH_LEN_ASC: begin
            acc_nxt = ls.acc;
            cnt_nxt = ls.cnt;
            if (ls.fail) begin
              failed_nxt = 1'b1;
            end else if (ls.done) begin
              case (phase_r)
                PH_LEN_ES: begin
                  es_end_nxt = ls.e;
                  if (ls.acc < ACC_W'(MIN_ES_LEN)) failed_nxt = 1'b1;
                  skip_nxt  = 8'(ES_ID_SKIP);
                  phase_nxt = PH_ES_ID;
                end
                PH_LEN_DC: begin
                  dc_end_nxt = ls.e;
                  if (ls.acc < ACC_W'(MIN_DC_LEN)) failed_nxt = 1'b1;
                  phase_nxt = PH_DC_OBJ;
                end
                default: begin
                  asc_end_nxt   = ls.e;
                  asc_start_nxt = p1;
                  if (ls.acc < ACC_W'(MIN_ASC_LEN)) failed_nxt = 1'b1;
                  phase_nxt = PH_DONE;
                end
              endcase
            end
          end
          PH_ES_ID: begin
            skip_nxt = skip_r - 8'd1;
            if (skip_r == 8'd1) phase_nxt = PH_ES_FLAGS;
          end
          PH_ES_FLAGS, PH_ES_SKIP, PH_URL_LEN: begin
            if ((phase_r == PH_URL_LEN) && (END_W'(in_byte) > (es_end_r - p1))) begin
              failed_nxt = 1'b1;
            end else if ((phase_r == PH_URL_LEN) && (in_byte != 8'd0)) begin
              skip_nxt  = in_byte;
              phase_nxt = PH_ES_SKIP;
            end else if ((phase_r == PH_ES_SKIP) && (skip_r != 8'd1)) begin
              skip_nxt = skip_r - 8'd1;
            end else begin
              opt_nxt = esn.opt;
              if (esn.fail) begin
                failed_nxt = 1'b1;
              end else begin
                phase_nxt = esn.ph;
                if (esn.ld_skip) skip_nxt = 8'(OPT_SKIP);
              end
            end
          end
          PH_TAG_DC: begin
            if ((pe >= es_end_r) || (in_byte != TAG_DC)) begin
              failed_nxt = 1'b1;
            end else begin
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_LEN_DC;
            end
          end
          PH_DC_OBJ: begin
            if (in_byte != OBJ_AUDIO) failed_nxt = 1'b1;
            else phase_nxt = PH_DC_ST;
          end
          PH_DC_ST: begin
            if (in_byte[7:2] != STREAM_AUDIO) begin
              failed_nxt = 1'b1;
            end else begin
              skip_nxt  = 8'(DC_SKIP_LEN);
              phase_nxt = PH_DC_SKIP;
            end
          end
          PH_DC_SKIP: begin
            skip_nxt = skip_r - 8'd1;
            if (skip_r == 8'd1) phase_nxt = PH_TAG_ASC;
          end
          PH_TAG_ASC: begin
            if ((pe >= dc_end_r) || (in_byte != TAG_ASC)) begin
              failed_nxt = 1'b1;
            end else begin
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_LEN_ASC;
            end
          end
          default: begin
            failed_nxt = 1'b1;
          end
        endcase
      end
    end

    // The first eight bytes are parsed as if no box were present. When they
    // turn out to be an esds box header, that guess is thrown away.
    if (take && (pos_r == POS_W'(HDR_LAST)) && hdr.tag_hit) begin
      phase_nxt    = PH_VF;
      box_mode_nxt = 1'b1;
      box_size_nxt = hdr.size;
      failed_nxt   = (hdr.size < BOX_MIN_SIZE);
    end

    fin.ok_pre    = !failed_nxt && (phase_nxt == PH_DONE);
    fin.box_mode  = box_mode_nxt;
    fin.box_size  = box_size_nxt;
    fin.es_end    = es_end_nxt;
    fin.asc_start = asc_start_nxt;
    fin.asc_end   = asc_end_nxt;
    fin.count     = END_W'(pos_nxt);
    fin_load      = take && in_last;

    if (take && in_last) begin
      phase_nxt    = PH_VF;
      pos_nxt      = '0;
      failed_nxt   = 1'b0;
      box_mode_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    box_size_r  <= box_size_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    es_end_r    <= es_end_nxt;
    dc_end_r    <= dc_end_nxt;
    asc_end_r   <= asc_end_nxt;
    asc_start_r <= asc_start_nxt;
    opt_r       <= opt_nxt;
    skip_r      <= skip_nxt;
    if (!rst_n) begin
      phase_r    <= PH_VF;
      pos_r      <= '0;
      failed_r   <= 1'b0;
      box_mode_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      failed_r   <= failed_nxt;
      box_mode_r <= box_mode_nxt;
    end
  end

  `ESDSL_ASSERT(a_pos_bound, pos_r <= POS_W'(MAX_BYTES), "byte position passed the limit")
  `ESDSL_ASSERT(a_restart, take && in_last |=> pos_r == '0 && phase_r == PH_VF && !failed_r, "engine did not restart after the final byte")
  `ESDSL_ASSERT(a_box_at_hdr, $rose(box_mode_r) |-> pos_r == POS_W'(HDR_LEN), "box mode entered away from the header end")

endmodule

// File: design/esdsl_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esdsl_result
// Two result stages: the first holds the engine state captured on the final
// byte, the second makes the closing checks and presents the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esdsl_result
  import esdsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fin_load,
  input  fin_t             fin,
  output logic             fin_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [OUT_W-1:0] out_asc_offset,
  output logic [OUT_W-1:0] out_asc_length
);

  localparam logic [END_W-1:0] OFS_LIMIT = END_W'(OFS_MAX);

  logic             fin_vld_r, fin_vld_nxt;
  fin_t             fin_r;
  logic             out_vld_r, out_vld_nxt;
  logic             found_r,   found_nxt;
  logic [OUT_W-1:0] ofs_r,     ofs_nxt;
  logic [OUT_W-1:0] len_r,     len_nxt;

  logic             fin_adv;
  logic             ok;
  logic [END_W-1:0] span;

  always_comb begin
    fin_adv  = fin_vld_r && (!out_vld_r || out_ready);
    fin_free = !fin_vld_r || fin_adv;

    span = fin_r.asc_end - fin_r.asc_start;
    ok   = fin_r.ok_pre &&
           (fin_r.box_mode ? (fin_r.box_size <= 32'(fin_r.count))
                           : (fin_r.es_end <= fin_r.count)) &&
           (fin_r.asc_start <= OFS_LIMIT) &&
           (fin_r.asc_end >= fin_r.asc_start) &&
           (span <= OFS_LIMIT);

    fin_vld_nxt = fin_load ? 1'b1 : (fin_adv ? 1'b0 : fin_vld_r);

    out_vld_nxt = out_vld_r;
    found_nxt   = found_r;
    ofs_nxt     = ofs_r;
    len_nxt     = len_r;
    if (fin_adv) begin
      out_vld_nxt = 1'b1;
      found_nxt   = ok;
      ofs_nxt     = ok ? fin_r.asc_start[OUT_W-1:0] : '0;
      len_nxt     = ok ? span[OUT_W-1:0] : '0;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) fin_r <= fin;
    found_r <= found_nxt;
    ofs_r   <= ofs_nxt;
    len_r   <= len_nxt;
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= fin_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_found      = found_r;
  assign out_asc_offset = ofs_r;
  assign out_asc_length = len_r;

  `ESDSL_ASSERT(a_no_overrun, fin_load |-> fin_free, "final state captured over a pending one")
  `ESDSL_ASSERT(a_min_len, out_vld_r && found_r |-> len_r >= OUT_W'(MIN_ASC_LEN), "config shorter than the minimum reported as found")
  `ESDSL_ASSERT(a_reject_zero, out_vld_r && !found_r |-> ofs_r == '0 && len_r == '0, "rejected result carries offset or length")
  `ESDSL_ASSERT_RST(a_reset_empty, !rst_n |=> !out_vld_r && !fin_vld_r, "result stages not empty after reset")

endmodule

// File: design/esds_audio_config_locator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esds_audio_config_locator_core
// Locates the AudioSpecificConfig in an esds payload streamed one byte per
// request and reports its offset and length after the final byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       in         in_valid / in_ready   in_data_byte, in_last_byte
//   out_      out        out_valid / out_ready out_found, out_asc_offset,
//                                              out_asc_length
//
// One byte is taken in every cycle while in_ready is high; the per-byte work
// is a single pass of the parsing engine between its state registers.
// A result leaves after its final byte, through two result stages.
// in_ready only falls when both result stages hold undelivered results.
// Synchronous active-low reset empties the result stages and restarts the
// engine at the start of a buffer; no clearing pass is needed.
//
module esds_audio_config_locator_core
  import esdsl_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [OUT_W-1:0] out_asc_offset,
  output logic [OUT_W-1:0] out_asc_length
);

  logic      take;
  logic      fin_free;
  logic      fin_load;
  fin_t      fin;
  hdr_info_t hdr;

  assign in_ready = fin_free;
  assign take     = in_valid && fin_free;

  esdsl_hdr u_hdr (
    .clk     (clk),
    .take    (take),
    .in_byte (in_data_byte),
    .hdr     (hdr)
  );

  esdsl_parser #(
    .MAX_BYTES (MAX_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_byte  (in_data_byte),
    .in_last  (in_last_byte),
    .hdr      (hdr),
    .fin_load (fin_load),
    .fin      (fin)
  );

  esdsl_result u_result (
    .clk            (clk),
    .rst_n          (rst_n),
    .fin_load       (fin_load),
    .fin            (fin),
    .fin_free       (fin_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_asc_offset (out_asc_offset),
    .out_asc_length (out_asc_length)
  );

endmodule
